/* design/barc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package barc_pkg;

  localparam int HEAP_BYTES   = 1024;
  localparam int HEADER_BYTES = 4;
  localparam int WORD_BITS    = 64;
  localparam int WORD_COUNT   = (HEAP_BYTES + WORD_BITS - 1) / WORD_BITS;
  localparam int MAX_RUN      = 63;
  localparam int ADDR_W       = $clog2(HEAP_BYTES);
  localparam int WIDX_W       = $clog2(WORD_COUNT);
  localparam int POS_W        = $clog2(WORD_BITS);
  localparam int LEN_W        = 6;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [1:0]           cmd_t;
  typedef logic [1:0]           status_t;

  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_FREE  = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_BAD_SIZE   = 2'd1;
  localparam status_t STATUS_FULL       = 2'd2;
  localparam status_t STATUS_BAD_HANDLE = 2'd3;

  typedef struct packed {
    logic              prime;
    logic              shift;
    logic              alloc_en;
    logic              free_en;
    logic [LEN_W-1:0]  run_len;
    logic [WIDX_W-1:0] step;
    logic [WIDX_W-1:0] free_word;
    logic [POS_W-1:0]  free_pos;
    logic [LEN_W-1:0]  free_len;
  } barc_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [WIDX_W-1:0] widx;
    logic [POS_W-1:0]  pos;
    logic              empty;
  } barc_scan_t;

  function automatic word_t run_starts(input word_t free_bits, input logic [LEN_W-1:0] len);
    word_t            p [LEN_W];
    word_t            acc;
    logic [LEN_W-1:0] off;
    p[0] = free_bits;
    for (int k = 1; k < LEN_W; k++) begin
      p[k] = p[k-1] & (p[k-1] >> (1 << (k - 1)));
    end
    acc = '1;
    off = '0;
    for (int k = 0; k < LEN_W; k++) begin
      if (len[k]) begin
        acc = acc & (p[k] >> off);
        off = off + LEN_W'(1 << k);
      end
    end
    return acc;
  endfunction

  function automatic logic [POS_W-1:0] lowest_pos(input word_t x);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (x[i]) begin
        pos = POS_W'(i);
      end
    end
    return pos;
  endfunction

  function automatic word_t run_mask(input logic [LEN_W-1:0] len, input logic [POS_W-1:0] pos);
    word_t m;
    m = (word_t'(1) << len) - word_t'(1);
    return m << pos;
  endfunction

endpackage
`default_nettype wire

/* design/barc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module barc_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           shift,
  input  wire barc_pkg::word_t d,
  output barc_pkg::word_t      q
);
  import barc_pkg::*;

  word_t word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else if (shift) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule
`default_nettype wire

/* design/barc_head.sv */
`timescale 1ns / 1ps
`default_nettype none
module barc_head (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire barc_pkg::barc_ctrl_t ctrl,
  input  wire barc_pkg::word_t      head_word,
  input  wire barc_pkg::word_t      next_word,
  output barc_pkg::word_t           tail_word,
  output barc_pkg::barc_scan_t      scan
);
  import barc_pkg::*;

  word_t             starts_r, starts_nxt;
  logic              found_r, found_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              empty_r, empty_nxt;
  logic              hit;
  logic [POS_W-1:0]  hit_pos;

  always_comb begin
    hit     = ctrl.alloc_en && !found_r && (starts_r != '0);
    hit_pos = lowest_pos(starts_r);

    tail_word = head_word;
    if (hit) begin
      tail_word = head_word | run_mask(ctrl.run_len, hit_pos);
    end else if (ctrl.free_en && (ctrl.step == ctrl.free_word)) begin
      tail_word = head_word & ~run_mask(ctrl.free_len, ctrl.free_pos);
    end

    starts_nxt = starts_r;
    found_nxt  = found_r;
    widx_nxt   = widx_r;
    pos_nxt    = pos_r;
    empty_nxt  = empty_r;
    if (ctrl.prime) begin
      starts_nxt = run_starts(~head_word, ctrl.run_len);
      found_nxt  = 1'b0;
      empty_nxt  = 1'b1;
    end else if (ctrl.shift) begin
      starts_nxt = run_starts(~next_word, ctrl.run_len);
      empty_nxt  = empty_r && (tail_word == '0);
      if (hit) begin
        found_nxt = 1'b1;
        widx_nxt  = ctrl.step;
        pos_nxt   = hit_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      empty_r <= 1'b1;
    end else begin
      found_r <= found_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    starts_r <= starts_nxt;
    widx_r   <= widx_nxt;
    pos_r    <= pos_nxt;
  end

  assign scan.found = found_r;
  assign scan.widx  = widx_r;
  assign scan.pos   = pos_r;
  assign scan.empty = empty_r;

endmodule
`default_nettype wire

/* design/barc_len_store.sv */
`timescale 1ns / 1ps
`default_nettype none
module barc_len_store (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [barc_pkg::ADDR_W-1:0]  rd_addr,
  output logic [barc_pkg::LEN_W-1:0]        rd_data,
  input  wire logic                         wr_en,
  input  wire logic [barc_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [barc_pkg::LEN_W-1:0]   wr_data,
  output logic                              clearing
);
  import barc_pkg::*;

  logic [LEN_W-1:0] mem [HEAP_BYTES];
  logic [LEN_W-1:0] rd_data_r;
  logic [ADDR_W:0]  clr_cnt_r, clr_cnt_nxt;

  assign clearing    = (clr_cnt_r != (ADDR_W + 1)'(HEAP_BYTES));
  assign clr_cnt_nxt = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt_r[ADDR_W-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* design/bitmap_run_allocator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// First-fit byte heap allocator, one busy bit per heap byte. Every command
// (allocate, free, query) raises its result beat after these steps: the scan
// head is primed while the run-length store read, issued as the command is
// captured, lands; the bitmap words rotate once through a ring of word cells
// past the single scan head; and the result is posted and the run-length store
// updated, once no earlier result still waits stalled in the output register.
// The next command is taken in the cycle after the result is posted.
// One command is in flight at a time; a new one is taken while the previous
// result still waits in the output register.
// After reset the run-length store is cleared, all 1024 entries in turn, while
// in_stall stays high.
module bitmap_run_allocator_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_command,
  input  wire logic [9:0]                  in_request_size,
  input  wire logic [9:0]                  in_free_handle,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [9:0]                       out_handle,
  output logic                             out_heap_empty
);
  import barc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic              size_ok_r;
  logic [LEN_W-1:0]  run_len_r;
  logic [ADDR_W-1:0] fh_r;
  logic              free_ok_r;
  logic [LEN_W-1:0]  free_len_r;
  logic [WIDX_W-1:0] step_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_handle_r;
  logic              out_empty_r;

  logic              accept;
  logic              out_free;
  logic              clearing;
  logic [ADDR_W:0]   total;
  logic [ADDR_W-1:0] free_start;
  logic [ADDR_W-1:0] alloc_handle;
  logic [LEN_W-1:0]  rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0]  wr_data;
  status_t           status_calc;
  logic              alloc_ok;

  barc_ctrl_t        ctrl;
  barc_scan_t        scan;
  word_t             cell_q [WORD_COUNT];
  word_t             tail_word;

  assign in_stall = (state_r != ST_IDLE) || clearing;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign total    = {1'b0, in_request_size} + (ADDR_W + 1)'(HEADER_BYTES);
  assign free_start   = fh_r - ADDR_W'(HEADER_BYTES);
  assign alloc_handle = ADDR_W'({scan.widx, scan.pos}) + ADDR_W'(HEADER_BYTES);
  assign alloc_ok     = (cmd_r == CMD_ALLOC) && size_ok_r && scan.found;

  always_comb begin
    ctrl.prime     = (state_r == ST_PREP);
    ctrl.shift     = (state_r == ST_SCAN);
    ctrl.alloc_en  = (cmd_r == CMD_ALLOC) && size_ok_r;
    ctrl.free_en   = free_ok_r;
    ctrl.run_len   = run_len_r;
    ctrl.step      = step_r;
    ctrl.free_word = free_start[ADDR_W-1:POS_W];
    ctrl.free_pos  = free_start[POS_W-1:0];
    ctrl.free_len  = free_len_r;
  end

  always_comb begin
    status_calc = STATUS_OK;
    if (cmd_r == CMD_ALLOC) begin
      if (!size_ok_r) begin
        status_calc = STATUS_BAD_SIZE;
      end else if (!scan.found) begin
        status_calc = STATUS_FULL;
      end
    end else if (cmd_r == CMD_FREE) begin
      if (!free_ok_r) begin
        status_calc = STATUS_BAD_HANDLE;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fh_r;
    wr_data = '0;
    if ((state_r == ST_DONE) && out_free) begin
      if (alloc_ok) begin
        wr_en   = 1'b1;
        wr_addr = alloc_handle;
        wr_data = run_len_r;
      end else if (free_ok_r) begin
        wr_en = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_SCAN;
      ST_SCAN: if (step_r == WIDX_W'(WORD_COUNT - 1)) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      free_ok_r   <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_PREP) begin
        free_ok_r <= (cmd_r == CMD_FREE) && (fh_r >= ADDR_W'(HEADER_BYTES)) && (rd_data != '0);
        step_r    <= '0;
      end else if (state_r == ST_SCAN) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_command;
      size_ok_r <= (in_request_size != '0) && (total <= (ADDR_W + 1)'(MAX_RUN));
      run_len_r <= total[LEN_W-1:0];
      fh_r      <= in_free_handle;
    end
    if (state_r == ST_PREP) begin
      free_len_r <= rd_data;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_status_r <= status_calc;
      out_handle_r <= alloc_ok ? alloc_handle : '0;
      out_empty_r  <= scan.empty;
    end
  end

  barc_len_store u_len_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (in_free_handle),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  barc_head u_head (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .head_word (cell_q[0]),
    .next_word (cell_q[1]),
    .tail_word (tail_word),
    .scan      (scan)
  );

  for (genvar i = 0; i < WORD_COUNT; i++) begin : g_cell
    if (i == WORD_COUNT - 1) begin : g_tail
      barc_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ctrl.shift),
        .d     (tail_word),
        .q     (cell_q[i])
      );
    end else begin : g_body
      barc_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ctrl.shift),
        .d     (cell_q[i+1]),
        .q     (cell_q[i])
      );
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handle     = out_handle_r;
  assign out_heap_empty = out_empty_r;

endmodule
`default_nettype wire

/* tb/sv/tb_bitmap_run_allocator_core.sv */
`timescale 1ns / 1ps
module tb_bitmap_run_allocator_core;
  import barc_pkg::*;

  localparam cmd_t CMD_UNUSED    = 2'd3;
  localparam int   N_RANDOM      = 600;
  localparam int   STALL_LIMIT   = 4000;
  localparam int   HOLD_CYCLES   = 400;
  localparam int   DRAIN_CYCLES  = 40;

  typedef struct {
    cmd_t              command;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] free_handle;
    bit                from_live;
  } heap_cmd_t;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] handle;
    logic              heap_empty;
  } heap_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_command = '0;
  logic [9:0]        in_request_size = '0;
  logic [9:0]        in_free_handle = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [9:0]        out_handle;
  logic              out_heap_empty;

  word_t             busy_words [WORD_COUNT];
  logic [LEN_W-1:0]  run_len_at [HEAP_BYTES];
  int                live_handles [$];
  heap_cmd_t         pending_cmds [$];
  heap_resp_t        expected_resps [$];
  heap_cmd_t         on_wire;

  int total_items = 1;
  int n_in = 0;
  int n_out = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int n_alloc_ok = 0, n_full = 0, n_bad_size = 0;
  int n_free_ok = 0, n_bad_handle = 0, n_other = 0;

  bitmap_run_allocator_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_request_size(in_request_size),
    .in_free_handle (in_free_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_handle     (out_handle),
    .out_heap_empty (out_heap_empty)
  );

  always #2 clk = ~clk;

  function automatic int idle_pct(input int phase, input bit sender);
    if (phase == 0) return sender ? 38 : 53;
    if (phase == 1) return sender ? 53 : 38;
    return 0;
  endfunction

  function automatic void push_cmd(input cmd_t c, input int req, input int fh,
                                   input bit live);
    heap_cmd_t item;
    item.command      = c;
    item.request_size = ADDR_W'(req);
    item.free_handle  = ADDR_W'(fh);
    item.from_live    = live;
    pending_cmds.push_back(item);
  endfunction

  // First-fit allocation over the busy-bit words, run lengths kept per handle.
  task automatic apply_command(input heap_cmd_t c, output heap_resp_t r);
    int    total;
    int    pos;
    int    start;
    int    h;
    int    idx;
    word_t starts;
    word_t mask;
    bit    placed;
    r.status     = STATUS_OK;
    r.handle     = '0;
    r.heap_empty = 1'b0;
    case (c.command)
      CMD_ALLOC: begin
        total = int'(c.request_size) + HEADER_BYTES;
        if (c.request_size == 0 || total == 0 || total > MAX_RUN) begin
          r.status = STATUS_BAD_SIZE;
          n_bad_size++;
        end else begin
          placed = 1'b0;
          for (int w = 0; w < WORD_COUNT && !placed; w++) begin
            starts = ~busy_words[w];
            for (int i = 1; i < total; i++) starts &= starts >> 1;
            if (starts != '0) begin
              pos = 0;
              while (!starts[pos]) pos++;
              busy_words[w] |= ((word_t'(1) << total) - word_t'(1)) << pos;
              start = w * WORD_BITS + pos;
              h = start + HEADER_BYTES;
              run_len_at[h] = LEN_W'(total);
              live_handles.push_back(h);
              r.handle = ADDR_W'(h);
              placed = 1'b1;
            end
          end
          if (placed) n_alloc_ok++;
          else begin
            r.status = STATUS_FULL;
            n_full++;
          end
        end
      end
      CMD_FREE: begin
        h = int'(c.free_handle);
        if (h < HEADER_BYTES || h >= HEAP_BYTES || run_len_at[h] == 0) begin
          r.status = STATUS_BAD_HANDLE;
          n_bad_handle++;
        end else begin
          start = h - HEADER_BYTES;
          mask = ((word_t'(1) << run_len_at[h]) - word_t'(1)) << (start % WORD_BITS);
          busy_words[start / WORD_BITS] &= ~mask;
          run_len_at[h] = '0;
          idx = -1;
          foreach (live_handles[i]) if (live_handles[i] == h) idx = i;
          if (idx >= 0) live_handles.delete(idx);
          n_free_ok++;
        end
      end
      default: n_other++;
    endcase
    r.heap_empty = 1'b1;
    for (int w = 0; w < WORD_COUNT; w++) if (busy_words[w] != '0) r.heap_empty = 1'b0;
  endtask

  always @(posedge clk) begin : drive
    heap_resp_t resp;
    heap_cmd_t  nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(on_wire, resp);
        expected_resps.push_back(resp);
        n_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 &&
            $urandom_range(0, 99) >= idle_pct(n_in * 3 / total_items, 1'b1)) begin
          nxt = pending_cmds.pop_front();
          if (nxt.from_live && live_handles.size() != 0)
            nxt.free_handle = ADDR_W'(live_handles[$urandom_range(0, live_handles.size() - 1)]);
          on_wire         = nxt;
          in_valid        <= 1'b1;
          in_command      <= nxt.command;
          in_request_size <= nxt.request_size;
          in_free_handle  <= nxt.free_handle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    heap_resp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (expected_resps.size() == 0) begin
          $error("unexpected result beat: status %0d handle %0d heap_empty %0b",
                 out_status, out_handle, out_heap_empty);
          errors++;
        end else begin
          want = expected_resps.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errors++;
          end
          if (out_handle !== want.handle) begin
            $error("handle: expected %0d, actual %0d", want.handle, out_handle);
            errors++;
          end
          if (out_heap_empty !== want.heap_empty) begin
            $error("heap_empty: expected %0b, actual %0b", want.heap_empty, out_heap_empty);
            errors++;
          end
        end
      end
      // hold off once for a long stretch so the input backs up
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && n_out >= 120) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(0, 99) < idle_pct(n_out * 3 / total_items, 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int  roll;
    int  sz;
    bit  alloc_heavy;
    foreach (busy_words[i]) busy_words[i] = '0;
    foreach (run_len_at[i]) run_len_at[i] = '0;

    push_cmd(CMD_QUERY, 1023, 1023, 1'b0);
    push_cmd(CMD_ALLOC, 0, 0, 1'b0);
    push_cmd(CMD_ALLOC, 1023, 512, 1'b0);
    push_cmd(CMD_ALLOC, 60, 0, 1'b0);
    push_cmd(CMD_ALLOC, 59, 1023, 1'b0);
    push_cmd(CMD_ALLOC, 1, 0, 1'b0);
    push_cmd(CMD_FREE, 0, 0, 1'b0);
    push_cmd(CMD_FREE, 1023, 3, 1'b0);
    push_cmd(CMD_FREE, 0, 1023, 1'b0);
    push_cmd(CMD_FREE, 0, 5, 1'b0);
    push_cmd(CMD_UNUSED, 1023, 1023, 1'b0);
    push_cmd(CMD_UNUSED, 0, 0, 1'b0);
    push_cmd(CMD_FREE, 0, 4, 1'b0);
    push_cmd(CMD_FREE, 0, 4, 1'b0);
    push_cmd(CMD_QUERY, 0, 0, 1'b0);
    push_cmd(CMD_ALLOC, 59, 0, 1'b0);
    push_cmd(CMD_ALLOC, 59, 0, 1'b0);
    push_cmd(CMD_ALLOC, 2, 0, 1'b0);
    push_cmd(CMD_FREE, 0, 0, 1'b1);
    push_cmd(CMD_FREE, 0, 0, 1'b1);
    push_cmd(CMD_FREE, 0, 0, 1'b1);
    push_cmd(CMD_FREE, 0, 0, 1'b1);
    push_cmd(CMD_QUERY, 512, 512, 1'b0);

    // alternate alloc-heavy and free-heavy stretches to fill and drain the heap
    for (int i = 0; i < N_RANDOM; i++) begin
      alloc_heavy = ((i / 60) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < (alloc_heavy ? 75 : 25)) begin
        case ($urandom_range(0, 19))
          0, 1, 2: sz = $urandom_range(0, 1023);
          3:       sz = 59;
          4:       sz = 1;
          default: sz = $urandom_range(1, 40);
        endcase
        push_cmd(CMD_ALLOC, sz, $urandom_range(0, 1023), 1'b0);
      end else if (roll < 92) begin
        push_cmd(CMD_FREE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 99) < 80);
      end else if (roll < 97) begin
        push_cmd(CMD_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023), 1'b0);
      end else begin
        push_cmd(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023), 1'b0);
      end
    end
    total_items = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_resps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_resps.size() != 0) begin
      $error("%0d expected results never arrived", expected_resps.size());
      errors += expected_resps.size();
    end
    $display("ran %0d commands: %0d allocations placed, %0d heap full, %0d bad size",
             n_in, n_alloc_ok, n_full, n_bad_size);
    $display("  %0d frees released, %0d bad handles, %0d query or unused commands",
             n_free_ok, n_bad_handle, n_other);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/barc_pkg.sv
design/barc_cell.sv
design/barc_head.sv
design/barc_len_store.sv
design/bitmap_run_allocator_core.sv
tb/sv/tb_bitmap_run_allocator_core.sv
